/* hdl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rfdl_pkg.sv */
`timescale 1ns / 1ps

package rfdl_pkg;

    localparam int MAX_LEN     = 32768;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int CMD_W       = 2;
    localparam int IDX_W       = 15;
    localparam int FRAC_W      = 16;
    localparam int NLEN_W      = 16;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESIZE = 2'd2;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quot;
        logic [LEN_W-1:0] rem;
    } div_rsp_t;

endpackage

/* hdl/resizable_fractional_delay_line_unit.sv */
// Resizable fractional delay line: a ring of samples with linear-interpolated taps and
// nearest-neighbour resizing, held in a simple dual-port sample RAM plus a scratch RAM used
// during resize. After reset a clearing pass writes zero to all 32768 sample entries,
// one per cycle, and s_ready stays low until it is done. A write request is stored in
// the cycle it is accepted. A read request goes straight to its tap fetches when
// tap_index is below the current length and otherwise first waits on the shared divider
// that reduces the index modulo the length; the two taps come out of the sample RAM one
// after the other. A resize to a new length n runs a divider pass for the source step,
// n reads copying into scratch, a divider pass for the new read base and n writes back,
// the copy and write-back phases each making one RAM access per cycle; a resize to the
// current length starts no divider pass. Only reads give a result; it sits in an output
// register, so the next request is taken while it waits for m_ready.
`timescale 1ns / 1ps

module resizable_fractional_delay_line_unit #(
    parameter int SAMPLE_BITS = rfdl_pkg::SAMPLE_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rfdl_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic [rfdl_pkg::IDX_W-1:0]    s_tap_index,
    input  logic [rfdl_pkg::FRAC_W-1:0]   s_tap_fraction,
    input  logic [rfdl_pkg::NLEN_W-1:0]   s_new_length,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic [rfdl_pkg::LEN_W-1:0]    m_length_now
);

    localparam int ADDR_W = rfdl_pkg::ADDR_W;
    localparam int LEN_W  = rfdl_pkg::LEN_W;
    localparam int SUM_W  = LEN_W + 1;
    localparam int FRAC_W = rfdl_pkg::FRAC_W;
    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = SB + FRAC_W + 2;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(rfdl_pkg::MAX_LEN - 1);
    localparam logic [LEN_W-1:0]  FULL_LEN  = LEN_W'(rfdl_pkg::MAX_LEN);
    localparam logic [LEN_W-1:0]  TOP_LEN   = LEN_W'(rfdl_pkg::MAX_LEN - 1);

    typedef enum logic [12:0] {
        ST_CLEAR  = 13'b0000000000001,
        ST_IDLE   = 13'b0000000000010,
        ST_RMOD   = 13'b0000000000100,
        ST_RDA    = 13'b0000000001000,
        ST_RDB    = 13'b0000000010000,
        ST_MUL    = 13'b0000000100000,
        ST_OUT    = 13'b0000001000000,
        ST_SDIV   = 13'b0000010000000,
        ST_COPY   = 13'b0000100000000,
        ST_CDRAIN = 13'b0001000000000,
        ST_BDIV   = 13'b0010000000000,
        ST_BACK   = 13'b0100000000000,
        ST_BDRAIN = 13'b1000000000000
    } state_t;

    // v is below 2*m, so one subtract brings it into range
    function automatic logic [ADDR_W-1:0] fold(input logic [SUM_W-1:0] v,
                                               input logic [LEN_W-1:0] m);
        logic [SUM_W-1:0] d;
        d = v - SUM_W'(m);
        if (v >= SUM_W'(m)) begin
            return d[ADDR_W-1:0];
        end
        return v[ADDR_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [ADDR_W-1:0]   wp_reg, wp_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic                m_valid_reg, m_valid_next;
    logic                cp_wr_reg, cp_wr_next;
    logic                wb_reg, wb_next;

    logic [FRAC_W-1:0]        frac_reg, frac_next;
    logic [ADDR_W-1:0]        ptr_reg, ptr_next;
    logic [SB-1:0]            a_reg, a_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [LEN_W-1:0]         n_reg, n_next;
    logic [LEN_W-1:0]         q_reg, q_next;
    logic [LEN_W-1:0]         r0_reg, r0_next;
    logic [LEN_W-1:0]         acc_reg, acc_next;
    logic [ADDR_W-1:0]        k_reg, k_next;
    logic [ADDR_W-1:0]        cp_wk_reg, cp_wk_next;
    logic [ADDR_W-1:0]        wb_addr_reg, wb_addr_next;
    logic [SB-1:0]            m_sample_reg, m_sample_next;
    logic [LEN_W-1:0]         m_len_reg, m_len_next;

    logic              st_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [SB-1:0]     st_wdata;
    logic [ADDR_W-1:0] st_raddr;
    logic [SB-1:0]     st_rdata;
    logic [SB-1:0]     sc_rdata;

    rfdl_pkg::div_req_t div_req;
    rfdl_pkg::div_rsp_t div_rsp;

    logic               accept;
    logic [LEN_W-1:0]   n_clamp;
    logic [SUM_W-1:0]   acc_sum;
    logic               carry;
    logic signed [SB:0] diff;
    logic [SB+1:0]      interp;
    logic               last_k;
    logic               out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign n_clamp = (s_new_length == '0) ? LEN_W'(1) :
                     (s_new_length >= rfdl_pkg::NLEN_W'(rfdl_pkg::MAX_LEN)) ? TOP_LEN :
                     LEN_W'(s_new_length);

    // nearest-neighbour source step: quotient plus carried remainder
    assign acc_sum = SUM_W'(acc_reg) + SUM_W'(r0_reg);
    assign carry   = acc_sum >= SUM_W'(n_reg);
    assign last_k  = LEN_W'(k_reg) == n_reg - LEN_W'(1);

    assign diff   = {st_rdata[SB-1], st_rdata} - {a_reg[SB-1], a_reg};
    assign interp = {{2{a_reg[SB-1]}}, a_reg} + prod_reg[PROD_W-1:FRAC_W];

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        wp_next       = wp_reg;
        base_next     = base_reg;
        clr_next      = clr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cp_wr_next    = 1'b0;
        wb_next       = 1'b0;
        frac_next     = frac_reg;
        ptr_next      = ptr_reg;
        a_next        = a_reg;
        prod_next     = prod_reg;
        n_next        = n_reg;
        q_next        = q_reg;
        r0_next       = r0_reg;
        acc_next      = acc_reg;
        k_next        = k_reg;
        cp_wk_next    = cp_wk_reg;
        wb_addr_next  = wb_addr_reg;
        m_sample_next = m_sample_reg;
        m_len_next    = m_len_reg;

        st_we    = 1'b0;
        st_waddr = wb_addr_reg;
        st_wdata = sc_rdata;
        st_raddr = ptr_reg;
        div_req  = '0;

        if (wb_reg) begin
            st_we = 1'b1;
        end

        case (state_reg)
            ST_CLEAR: begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        rfdl_pkg::CMD_WRITE: begin
                            st_we     = 1'b1;
                            st_waddr  = wp_reg;
                            st_wdata  = s_sample_in;
                            wp_next   = fold(SUM_W'(wp_reg) + SUM_W'(1), len_reg);
                            base_next = fold(SUM_W'(base_reg) + SUM_W'(1), len_reg);
                        end
                        rfdl_pkg::CMD_READ: begin
                            frac_next = s_tap_fraction;
                            if (LEN_W'(s_tap_index) < len_reg) begin
                                ptr_next   = fold(SUM_W'(base_reg) + SUM_W'(s_tap_index),
                                                  len_reg);
                                state_next = ST_RDA;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = LEN_W'(s_tap_index);
                                div_req.divisor  = len_reg;
                                state_next       = ST_RMOD;
                            end
                        end
                        rfdl_pkg::CMD_RESIZE: begin
                            n_next = n_clamp;
                            if (n_clamp != len_reg) begin
                                div_req.start    = 1'b1;
                                div_req.dividend = len_reg;
                                div_req.divisor  = n_clamp;
                                state_next       = ST_SDIV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RMOD: begin
                if (div_rsp.done) begin
                    ptr_next   = fold(SUM_W'(base_reg) + SUM_W'(div_rsp.rem), len_reg);
                    state_next = ST_RDA;
                end
            end
            ST_RDA: begin
                ptr_next   = fold(SUM_W'(ptr_reg) + SUM_W'(1), len_reg);
                state_next = ST_RDB;
            end
            ST_RDB: begin
                a_next     = st_rdata;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = diff * $signed({1'b0, frac_reg});
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = interp[SB-1:0];
                    m_len_next    = len_reg;
                    state_next    = ST_IDLE;
                end
            end
            ST_SDIV: begin
                if (div_rsp.done) begin
                    q_next     = div_rsp.quot;
                    r0_next    = div_rsp.rem;
                    ptr_next   = wp_reg;
                    acc_next   = '0;
                    k_next     = '0;
                    state_next = ST_COPY;
                end
            end
            ST_COPY: begin
                // read old entry, scratch write lands in the cycle after
                cp_wr_next = 1'b1;
                cp_wk_next = k_reg;
                acc_next   = carry ? LEN_W'(acc_sum - SUM_W'(n_reg)) : LEN_W'(acc_sum);
                ptr_next   = fold(SUM_W'(ptr_reg) + SUM_W'(q_reg) + SUM_W'(carry), len_reg);
                k_next     = k_reg + ADDR_W'(1);
                if (last_k) begin
                    state_next = ST_CDRAIN;
                end
            end
            ST_CDRAIN: begin
                div_req.start    = 1'b1;
                div_req.dividend = LEN_W'(base_reg);
                div_req.divisor  = n_reg;
                state_next       = ST_BDIV;
            end
            ST_BDIV: begin
                if (div_rsp.done) begin
                    base_next  = div_rsp.rem[ADDR_W-1:0];
                    wp_next    = div_rsp.rem[ADDR_W-1:0];
                    ptr_next   = div_rsp.rem[ADDR_W-1:0];
                    len_next   = n_reg;
                    k_next     = '0;
                    state_next = ST_BACK;
                end
            end
            ST_BACK: begin
                wb_next      = 1'b1;
                wb_addr_next = ptr_reg;
                ptr_next     = fold(SUM_W'(ptr_reg) + SUM_W'(1), len_reg);
                k_next       = k_reg + ADDR_W'(1);
                if (last_k) begin
                    state_next = ST_BDRAIN;
                end
            end
            ST_BDRAIN: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            len_reg     <= FULL_LEN;
            wp_reg      <= LAST_ADDR;
            base_reg    <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            cp_wr_reg   <= 1'b0;
            wb_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            wp_reg      <= wp_next;
            base_reg    <= base_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            cp_wr_reg   <= cp_wr_next;
            wb_reg      <= wb_next;
        end
    end

    always_ff @(posedge aclk) begin
        frac_reg     <= frac_next;
        ptr_reg      <= ptr_next;
        a_reg        <= a_next;
        prod_reg     <= prod_next;
        n_reg        <= n_next;
        q_reg        <= q_next;
        r0_reg       <= r0_next;
        acc_reg      <= acc_next;
        k_reg        <= k_next;
        cp_wk_reg    <= cp_wk_next;
        wb_addr_reg  <= wb_addr_next;
        m_sample_reg <= m_sample_next;
        m_len_reg    <= m_len_next;
    end

    rfdl_ram #(
        .DEPTH (rfdl_pkg::MAX_LEN),
        .WIDTH (SAMPLE_BITS)
    ) u_sample_ram (
        .aclk    (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (st_raddr),
        .rd_data (st_rdata)
    );

    rfdl_ram #(
        .DEPTH (rfdl_pkg::MAX_LEN),
        .WIDTH (SAMPLE_BITS)
    ) u_scratch_ram (
        .aclk    (aclk),
        .wr_en   (cp_wr_reg),
        .wr_addr (cp_wk_reg),
        .wr_data (st_rdata),
        .rd_addr (k_reg),
        .rd_data (sc_rdata)
    );

    rfdl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_length_now = m_len_reg;

endmodule

/* hdl/rfdl_ram.sv */
`timescale 1ns / 1ps

module rfdl_ram #(
    parameter int DEPTH = rfdl_pkg::MAX_LEN,
    parameter int WIDTH = rfdl_pkg::SAMPLE_BITS
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/rfdl_div.sv */
`timescale 1ns / 1ps

module rfdl_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  rfdl_pkg::div_req_t  req,
    output rfdl_pkg::div_rsp_t  rsp
);

    localparam int W     = rfdl_pkg::LEN_W;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [W-1:0]     dvs_reg, dvs_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quot_reg[W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quot_next = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[W-1:0] : trial[W-1:0];
            quot_next = {quot_reg[W-2:0], fits};
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

/* hdl/rfdl_chk.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfdl_chk #(
    parameter int SAMPLE_BITS = rfdl_pkg::SAMPLE_BITS
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [rfdl_pkg::CMD_W-1:0]    s_cmd,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_sample_out,
    input logic [rfdl_pkg::LEN_W-1:0]    m_length_now
);

    localparam logic [rfdl_pkg::CMD_W-1:0] RD      = rfdl_pkg::CMD_READ;
    localparam logic [rfdl_pkg::LEN_W-1:0] LEN_MAX = rfdl_pkg::LEN_W'(rfdl_pkg::MAX_LEN);

    logic take;

    assign take = s_valid && s_ready;

    // a waiting result must hold until taken
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_out), "result dropped")

    // the clearing pass keeps requests out right after reset
    `ASSERT_IMPLY(a_clear, aclk, aresetn, $rose(aresetn), !s_ready, "request taken while clearing")

    // a read request keeps the block busy for its tap fetches
    `ASSERT_NEXT(a_rd_busy, aclk, aresetn, take && s_cmd == RD, !s_ready, "read overlapped next request")

    // no result can appear the cycle after a request with the output empty
    `ASSERT_NEXT(a_no_early, aclk, aresetn, take && !m_valid, !m_valid, "result appeared too early")

    // reported length stays in its legal range
    `ASSERT_IMPLY(a_len, aclk, aresetn, m_valid, m_length_now != '0 && m_length_now <= LEN_MAX, "bad length")

endmodule

bind resizable_fractional_delay_line_unit rfdl_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_rfdl_chk (.*);
